// File: src/chc_pkg.sv
// Package with shared types, constants and the arctangent table of the calibrated compass.
package chc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int BIAS_W    = 16;
  localparam int RADIUS_W  = 16;
  localparam int HEAD_W    = 16;
  localparam int Z_W       = 24;
  localparam int CFG_IDX_W = 3;
  localparam int ATAN_LEN  = 24;
  localparam int ATAN_IDX_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd5;

  localparam int SMALL_LIMIT  = 6;
  localparam int QUARTER_CDEG = 9000;
  localparam int HALF_CDEG    = 18000;
  localparam int HALF_Z       = 18000 * 256;
  localparam int ROUND_HALF   = 128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_CORDIC,
    S_ROUND,
    S_FIN
  } chc_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } chc_div_ctrl_t;

  // Arctangent of 2^-i in units of 1/256 centidegree.
  function automatic logic [Z_W-1:0] chc_atan(input logic [ATAN_IDX_W-1:0] i);
    logic [Z_W-1:0] a;
    case (i)
      5'd0:  a = 24'd1152000;
      5'd1:  a = 24'd680065;
      5'd2:  a = 24'd359328;
      5'd3:  a = 24'd182400;
      5'd4:  a = 24'd91554;
      5'd5:  a = 24'd45822;
      5'd6:  a = 24'd22916;
      5'd7:  a = 24'd11459;
      5'd8:  a = 24'd5730;
      5'd9:  a = 24'd2865;
      5'd10: a = 24'd1432;
      5'd11: a = 24'd716;
      5'd12: a = 24'd358;
      5'd13: a = 24'd179;
      5'd14: a = 24'd90;
      5'd15: a = 24'd45;
      5'd16: a = 24'd22;
      5'd17: a = 24'd11;
      5'd18: a = 24'd6;
      5'd19: a = 24'd3;
      5'd20: a = 24'd1;
      5'd21: a = 24'd1;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

// File: src/chc_div.sv
// Bit-serial restoring divider that produces one quotient bit per cycle while ctrl.step is set.
module chc_div #(
  parameter int NW = 33
) (
  input  logic                           clk,
  input  chc_pkg::chc_div_ctrl_t         ctrl,
  input  logic [NW-1:0]                  dividend,
  input  logic [chc_pkg::RADIUS_W-1:0]   divisor,
  output logic [NW-1:0]                  quotient
);

  logic [NW-1:0]                  acc;
  logic [chc_pkg::RADIUS_W-1:0]   rem;
  logic [chc_pkg::RADIUS_W:0]     trial;
  logic                           fits;

  assign trial = {rem, acc[NW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc <= dividend;
      rem <= '0;
    end else if (ctrl.step) begin
      acc <= {acc[NW-2:0], fits};
      if (fits) begin
        rem <= chc_pkg::RADIUS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[chc_pkg::RADIUS_W-1:0];
      end
    end
  end

  assign quotient = acc;

endmodule

// File: src/compass_heading_calibrated.sv
// Top level of the calibrated compass: bias and radius correction, serial division, CORDIC.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    mag_x, mag_y
//   out      output     out_valid / out_ready  heading_cdeg
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A computed item passes through S_DIV, S_SIGN, S_CORDIC, S_ROUND and S_FIN in that order;
// the bit-serial divide yields NW = max(SAMPLE_WIDTH, 16) + 16 quotient bits and the CORDIC
// runs NSTEP = min(CORDIC_STEPS, 24) steps. In hold mode an item goes from S_IDLE to S_FIN.
// Reset resets configuration, FSM, counter and last heading and empties the output register.
// A result waits in the output register while the next item is already being processed;
// the block stalls only in its last state while that register is still full.
module compass_heading_calibrated #(
  parameter int SAMPLE_WIDTH = chc_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = chc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  mag_x,
  input  logic signed [SAMPLE_WIDTH-1:0]  mag_y,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [chc_pkg::HEAD_W-1:0] heading_cdeg,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [chc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chc_pkg::BIAS_W-1:0]      cfg_data
);

  localparam int DW = ((SAMPLE_WIDTH > chc_pkg::BIAS_W) ? SAMPLE_WIDTH : chc_pkg::BIAS_W) + 1;
  localparam int MW = DW - 1;
  localparam int NW = MW + chc_pkg::RADIUS_W;
  localparam int CW = NW + 3;
  localparam int NSTEP = (CORDIC_STEPS > chc_pkg::ATAN_LEN) ? chc_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int CTW = $clog2(NW + 1);
  localparam int ZW = chc_pkg::Z_W;
  localparam int HW = chc_pkg::HEAD_W;

  chc_pkg::chc_state_t state, state_next;

  logic signed [chc_pkg::BIAS_W-1:0] bias_x, bias_y;
  logic [chc_pkg::RADIUS_W-1:0]      radius_x, radius_y;
  logic                              heading_negate, hold_heading;
  logic signed [HW-1:0]              last_heading;

  logic [CTW-1:0]        cnt;
  logic                  sx, sy, hold_item, nx_tiny;
  logic signed [HW-1:0]  hsmall, res;
  logic signed [CW-1:0]  x, y;
  logic signed [ZW-1:0]  z;

  logic                  in_xfer, out_load;
  logic signed [DW-1:0]  dx, dy;
  logic [DW-1:0]         dx_abs, dy_abs;
  logic [chc_pkg::RADIUS_W-1:0] rx, ry;
  logic [NW-1:0]         qx, qy;
  chc_pkg::chc_div_ctrl_t div_ctrl;

  logic                  nxneg, yneg, nyneg;
  logic signed [CW-1:0]  qyw, xs, ys;
  logic signed [ZW-1:0]  atan_v;
  logic [ZW-1:0]         zabs, zr;
  logic [HW-1:0]         qr, qc;
  logic signed [HW-1:0]  h_cordic, h_pick, h_final;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (state == chc_pkg::S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state == chc_pkg::S_FIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x         <= '0;
      bias_y         <= '0;
      radius_x       <= chc_pkg::RADIUS_W'(1);
      radius_y       <= chc_pkg::RADIUS_W'(1);
      heading_negate <= 1'b0;
      hold_heading   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        chc_pkg::CFG_BIAS_X:   bias_x <= cfg_data;
        chc_pkg::CFG_BIAS_Y:   bias_y <= cfg_data;
        chc_pkg::CFG_RADIUS_X: radius_x <= cfg_data;
        chc_pkg::CFG_RADIUS_Y: radius_y <= cfg_data;
        chc_pkg::CFG_NEGATE:   heading_negate <= cfg_data[0];
        chc_pkg::CFG_HOLD:     hold_heading <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign dx = DW'(mag_x) - DW'(bias_x);
  assign dy = DW'(mag_y) - DW'(bias_y);
  assign dx_abs = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign dy_abs = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign rx = (radius_x == '0) ? chc_pkg::RADIUS_W'(1) : radius_x;
  assign ry = (radius_y == '0) ? chc_pkg::RADIUS_W'(1) : radius_y;

  assign div_ctrl.load = in_xfer && !hold_heading;
  assign div_ctrl.step = (state == chc_pkg::S_DIV);

  chc_div #(.NW(NW)) u_div_x (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend ({dx_abs[MW-1:0], {chc_pkg::RADIUS_W{1'b0}}}),
    .divisor  (rx),
    .quotient (qx)
  );

  chc_div #(.NW(NW)) u_div_y (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend ({dy_abs[MW-1:0], {chc_pkg::RADIUS_W{1'b0}}}),
    .divisor  (ry),
    .quotient (qy)
  );

  assign nxneg = sx && (qx != '0);
  assign nyneg = sy && (qy != '0);
  assign yneg  = sy ^ nxneg;
  assign qyw   = CW'(qy);

  assign xs     = x >>> cnt;
  assign ys     = y >>> cnt;
  assign atan_v = $signed(chc_pkg::chc_atan(cnt[chc_pkg::ATAN_IDX_W-1:0]));

  assign zabs     = z[ZW-1] ? ZW'(-z) : ZW'(z);
  assign zr       = zabs + ZW'(chc_pkg::ROUND_HALF);
  assign qr       = zr[ZW-1:8];
  assign qc       = (qr > HW'(chc_pkg::HALF_CDEG)) ? HW'(chc_pkg::HALF_CDEG) : qr;
  assign h_cordic = z[ZW-1] ? $signed(qc) : $signed(HW'(-qc));
  assign h_pick   = nx_tiny ? hsmall : h_cordic;
  assign h_final  = heading_negate ? HW'(-h_pick) : h_pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chc_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_next = hold_heading ? chc_pkg::S_FIN : chc_pkg::S_DIV;
        end
      end
      chc_pkg::S_DIV: begin
        if (cnt == CTW'(NW - 1)) begin
          state_next = chc_pkg::S_SIGN;
        end
      end
      chc_pkg::S_SIGN: state_next = chc_pkg::S_CORDIC;
      chc_pkg::S_CORDIC: begin
        if (cnt == CTW'(NSTEP - 1)) begin
          state_next = chc_pkg::S_ROUND;
        end
      end
      chc_pkg::S_ROUND: state_next = chc_pkg::S_FIN;
      chc_pkg::S_FIN: begin
        if (out_load) begin
          state_next = chc_pkg::S_IDLE;
        end
      end
      default: state_next = chc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      out_valid    <= 1'b0;
      last_heading <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        if (!hold_item) begin
          last_heading <= res;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == chc_pkg::S_DIV && cnt != CTW'(NW - 1)) ||
          (state == chc_pkg::S_CORDIC && cnt != CTW'(NSTEP - 1))) begin
        cnt <= cnt + CTW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sx        <= dx[DW-1];
      sy        <= dy[DW-1];
      hold_item <= hold_heading;
    end
    if (state == chc_pkg::S_SIGN) begin
      nx_tiny <= (qx <= NW'(chc_pkg::SMALL_LIMIT));
      if (qx == '0) begin
        hsmall <= '0;
      end else if (sx) begin
        hsmall <= -HW'(chc_pkg::QUARTER_CDEG);
      end else begin
        hsmall <= HW'(chc_pkg::QUARTER_CDEG);
      end
      x <= CW'(qx);
      y <= yneg ? CW'(-qyw) : qyw;
      if (!nxneg) begin
        z <= '0;
      end else if (nyneg) begin
        z <= -ZW'(chc_pkg::HALF_Z);
      end else begin
        z <= ZW'(chc_pkg::HALF_Z);
      end
    end
    if (state == chc_pkg::S_CORDIC) begin
      if (!y[CW-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_v;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_v;
      end
    end
    if (state == chc_pkg::S_ROUND) begin
      res <= h_final;
    end
    if (out_load) begin
      heading_cdeg <= hold_item ? last_heading : res;
    end
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (heading_cdeg >= -16'sd18000) && (heading_cdeg <= 16'sd18000))
    else $error("heading out of range");

  a_cordic_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == chc_pkg::S_CORDIC) |-> (cnt < CTW'(NSTEP)))
    else $error("CORDIC step counter past the last step");

  a_hold_path: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && hold_heading) |=> (state == chc_pkg::S_FIN) && hold_item)
    else $error("hold transfer did not go straight to the result state");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == chc_pkg::S_IDLE))
    else $error("result not presented after the final state");

endmodule
